// ===== hw/rtl/smdr_pkg.sv =====
// ----------------------------------------------------------------------------
// smdr_pkg
// Types and constants shared by the signed multiply-divide-round block.
// ----------------------------------------------------------------------------
package smdr_pkg;

	localparam int unsigned WordW = 64;

	localparam logic CMD_FLOOR = 1'b0;
	localparam logic CMD_CEIL  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DIV  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic              command;
		logic signed [63:0] factor_a;
		logic signed [63:0] factor_b;
		logic signed [63:0] divisor;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] quotient_out;
		logic [1:0]         status;
	} out_word_t;

	// Word handed from the front part to the divider.
	typedef struct packed {
		logic        early;     // result already settled, quotient 0
		logic [1:0]  status;
		logic        negative;
		logic        ceil_req;
		logic [63:0] prod_hi;
		logic [63:0] prod_lo;
		logic [63:0] divisor;
	} mid_word_t;

endpackage

// ===== hw/rtl/smdr_fifo.sv =====
// ----------------------------------------------------------------------------
// smdr_fifo
// Small first-in first-out queue of words, shown on the read side at once.
// ----------------------------------------------------------------------------
module smdr_fifo #(
	parameter int unsigned DEPTH = 4,
	parameter type word_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  word_t wr_data,
	input  logic  rd_en,
	output word_t rd_data,
	output logic  full,
	output logic  empty
);
	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	word_t          mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic           do_wr, do_rd;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/smdr_front.sv =====
// ----------------------------------------------------------------------------
// smdr_front
// Takes words in, sorts out the special cases and forms the 128-bit product
// of the factor magnitudes over four stages.
// ----------------------------------------------------------------------------
module smdr_front
	import smdr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  item,
	input  logic      push,
	output logic      full,
	output mid_word_t mid_word,
	output logic      mid_push,
	input  logic      mid_full
);
	logic       adv;
	logic       v_s1, v_s2, v_s3, v_s4;
	in_word_t   item_s1;

	logic        early_s2, neg_s2, up_s2;
	logic [1:0]  st_s2;
	logic [63:0] mag_a_s2, mag_b_s2, div_s2;

	logic        early_s3, neg_s3, up_s3;
	logic [1:0]  st_s3;
	logic [63:0] ll_s3, lh_s3, hl_s3, hh_s3, div_s3;

	logic        early_s4, neg_s4, up_s4;
	logic [1:0]  st_s4;
	logic [127:0] prod_s4;
	logic [63:0]  div_s4;

	logic [63:0] a_u, b_u, c_u;

	// The whole front moves together; it holds only when its last word cannot leave.
	assign adv      = !(v_s4 && mid_full);
	assign full     = !adv;
	assign mid_push = v_s4 && adv;

	assign a_u = item_s1.factor_a;
	assign b_u = item_s1.factor_b;
	assign c_u = item_s1.divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;

			if (c_u == '0 || c_u[63]) begin
				early_s2 <= 1'b1;
				st_s2    <= ST_BAD_DIV;
			end else if (a_u == '0 || b_u == '0) begin
				early_s2 <= 1'b1;
				st_s2    <= ST_OK;
			end else begin
				early_s2 <= 1'b0;
				st_s2    <= ST_OK;
			end
			neg_s2   <= a_u[63] ^ b_u[63];
			up_s2    <= (item_s1.command == CMD_CEIL);
			mag_a_s2 <= a_u[63] ? (64'd0 - a_u) : a_u;
			mag_b_s2 <= b_u[63] ? (64'd0 - b_u) : b_u;
			div_s2   <= c_u;

			early_s3 <= early_s2;
			st_s3    <= st_s2;
			neg_s3   <= neg_s2;
			up_s3    <= up_s2;
			div_s3   <= div_s2;
			ll_s3    <= mag_a_s2[31:0]  * mag_b_s2[31:0];
			lh_s3    <= mag_a_s2[31:0]  * mag_b_s2[63:32];
			hl_s3    <= mag_a_s2[63:32] * mag_b_s2[31:0];
			hh_s3    <= mag_a_s2[63:32] * mag_b_s2[63:32];

			early_s4 <= early_s3;
			st_s4    <= st_s3;
			neg_s4   <= neg_s3;
			up_s4    <= up_s3;
			div_s4   <= div_s3;
			prod_s4  <= {hh_s3, ll_s3} + {32'd0, lh_s3, 32'd0} + {32'd0, hl_s3, 32'd0};
		end
	end

	always_comb begin
		mid_word.early    = early_s4;
		mid_word.status   = st_s4;
		mid_word.negative = neg_s4;
		mid_word.ceil_req = up_s4;
		mid_word.prod_hi  = prod_s4[127:64];
		mid_word.prod_lo  = prod_s4[63:0];
		mid_word.divisor  = div_s4;
	end

endmodule

// ===== hw/rtl/smdr_back.sv =====
// ----------------------------------------------------------------------------
// smdr_back
// Pipelined restoring divider, one quotient bit per stage, followed by
// rounding, range checks and a small result queue.
// ----------------------------------------------------------------------------
module smdr_back
	import smdr_pkg::*;
#(
	parameter int unsigned OUT_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  mid_word_t mid_word,
	input  logic      mid_empty,
	output logic      mid_pop,
	output out_word_t result,
	output logic      empty,
	input  logic      pop
);
	localparam int unsigned NStg = WordW;

	logic        adv, out_full, out_push;
	logic        v_q     [NStg+1];
	logic        early_q [NStg+1];
	logic [1:0]  st_q    [NStg+1];
	logic        neg_q   [NStg+1];
	logic        up_q    [NStg+1];
	logic [63:0] rem_q   [NStg+1];
	logic [63:0] lo_q    [NStg+1];
	logic [63:0] quo_q   [NStg+1];
	logic [63:0] div_q   [NStg+1];

	logic [63:0] trial [NStg];
	logic        take  [NStg];

	logic        bump;
	logic [63:0] q_fin;
	out_word_t   fin;

	assign adv      = !(v_q[NStg] && out_full);
	assign mid_pop  = adv && !mid_empty;
	assign out_push = adv && v_q[NStg];

	always_comb begin
		for (int k = 0; k < NStg; k++) begin
			// The running remainder stays below the divisor, so bit 63 is free.
			trial[k] = {rem_q[k][62:0], lo_q[k][63]};
			take[k]  = (trial[k] >= div_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NStg; k++) begin
				v_q[k] <= 1'b0;
			end
		end else if (adv) begin
			v_q[0] <= !mid_empty;
			for (int k = 0; k < NStg; k++) begin
				v_q[k+1] <= v_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!mid_word.early && mid_word.prod_hi >= mid_word.divisor) begin
				early_q[0] <= 1'b1;
				st_q[0]    <= ST_OVERFLOW;
			end else begin
				early_q[0] <= mid_word.early;
				st_q[0]    <= mid_word.status;
			end
			neg_q[0] <= mid_word.negative;
			up_q[0]  <= mid_word.ceil_req;
			rem_q[0] <= mid_word.prod_hi;
			lo_q[0]  <= mid_word.prod_lo;
			quo_q[0] <= '0;
			div_q[0] <= mid_word.divisor;
			for (int k = 0; k < NStg; k++) begin
				early_q[k+1] <= early_q[k];
				st_q[k+1]    <= st_q[k];
				neg_q[k+1]   <= neg_q[k];
				up_q[k+1]    <= up_q[k];
				div_q[k+1]   <= div_q[k];
				lo_q[k+1]    <= {lo_q[k][62:0], 1'b0};
				rem_q[k+1]   <= take[k] ? (trial[k] - div_q[k]) : trial[k];
				quo_q[k+1]   <= {quo_q[k][62:0], take[k]};
			end
		end
	end

	// Rounding moves the magnitude away from zero only for a nonzero remainder.
	always_comb begin
		bump  = (rem_q[NStg] != '0) && (neg_q[NStg] ? !up_q[NStg] : up_q[NStg]);
		q_fin = quo_q[NStg] + {63'd0, bump};
		fin.quotient_out = '0;
		fin.status       = ST_OK;
		if (early_q[NStg]) begin
			fin.status = st_q[NStg];
		end else if (bump && quo_q[NStg] == '1) begin
			fin.status = ST_OVERFLOW;
		end else if (neg_q[NStg]) begin
			if (q_fin > 64'h8000_0000_0000_0000) begin
				fin.status = ST_OVERFLOW;
			end else begin
				fin.quotient_out = 64'd0 - q_fin;
			end
		end else begin
			if (q_fin > 64'h7FFF_FFFF_FFFF_FFFF) begin
				fin.status = ST_OVERFLOW;
			end else begin
				fin.quotient_out = q_fin;
			end
		end
	end

	smdr_fifo #(
		.DEPTH  (OUT_DEPTH),
		.word_t (out_word_t)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (fin),
		.rd_en   (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty)
	);

endmodule

// ===== hw/rtl/signed_mul_div_round.sv =====
// ----------------------------------------------------------------------------
// signed_mul_div_round
// Floor or ceiling of a*b/c on signed 64-bit words, exact through a 128-bit
// product and a pipelined 128-by-64 division.
//
//   channel  direction  handshake        word
//   item     in         push / full      in_word_t
//   result   out        pop / empty      out_word_t
//
// One word is taken per cycle while full is low. A pushed word passes through
// four front stages, the queue, 65 divider stages and the result queue before
// it shows on the result ports.
// Reset clears all valid flags and queue pointers and counts; nothing else is cleared.
// When the result queue fills, the divider pipeline holds, then the middle
// queue fills and the front holds, which raises full.
// ----------------------------------------------------------------------------
module signed_mul_div_round
	import smdr_pkg::*;
#(
	parameter int unsigned MID_DEPTH = 4,
	parameter int unsigned OUT_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  item,
	input  logic      push,
	output logic      full,
	output out_word_t result,
	output logic      empty,
	input  logic      pop
);
	mid_word_t f_word, b_word;
	logic      f_push, q_full, q_empty, b_pop;

	smdr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.mid_word (f_word),
		.mid_push (f_push),
		.mid_full (q_full)
	);

	smdr_fifo #(
		.DEPTH  (MID_DEPTH),
		.word_t (mid_word_t)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_word),
		.rd_en   (b_pop),
		.rd_data (b_word),
		.full    (q_full),
		.empty   (q_empty)
	);

	smdr_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_word  (b_word),
		.mid_empty (q_empty),
		.mid_pop   (b_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== tb/sv/signed_mul_div_round_tb.sv =====
// ----------------------------------------------------------------------------
// signed_mul_div_round_tb
// Drives signed floor and ceiling scaling words into the block and checks
// every result word against an exact 128-bit prediction kept in order.
// ----------------------------------------------------------------------------
module signed_mul_div_round_tb;
	import smdr_pkg::*;

	class quotient_board;
		out_word_t pending[$];
		int unsigned mismatches;

		function out_word_t scale_round(in_word_t w);
			out_word_t res;
			logic [63:0] ma, mb, c, q, r;
			logic [127:0] prod;
			logic negative, bump;
			res = '0;
			c = w.divisor;
			if (c == 64'd0 || c[63]) begin
				res.status = ST_BAD_DIV;
				return res;
			end
			if (w.factor_a == 64'sd0 || w.factor_b == 64'sd0) return res;
			negative = w.factor_a[63] ^ w.factor_b[63];
			ma = w.factor_a[63] ? -w.factor_a : w.factor_a;
			mb = w.factor_b[63] ? -w.factor_b : w.factor_b;
			prod = {64'd0, ma} * {64'd0, mb};
			if (prod[127:64] >= c) begin
				res.status = ST_OVERFLOW;
				return res;
			end
			q = 64'(prod / {64'd0, c});
			r = 64'(prod % {64'd0, c});
			bump = (r != 64'd0) && (negative ? (w.command == CMD_FLOOR)
				: (w.command == CMD_CEIL));
			if (bump) begin
				if (q == '1) begin
					res.status = ST_OVERFLOW;
					return res;
				end
				q = q + 64'd1;
			end
			if (negative ? (q > 64'h8000_0000_0000_0000)
				: (q > 64'h7fff_ffff_ffff_ffff)) begin
				res.status = ST_OVERFLOW;
				return res;
			end
			res.quotient_out = negative ? -q : q;
			return res;
		endfunction

		function void note_word(in_word_t w);
			pending.push_back(scale_round(w));
		endfunction

		function void check_word(out_word_t got);
			out_word_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got.quotient_out !== exp.quotient_out || got.status !== exp.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected q=%0d st=%0d, got q=%0d st=%0d",
						exp.quotient_out, exp.status, got.quotient_out, got.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_word_t item = '0;
	logic push = 1'b0;
	logic full;
	out_word_t result;
	logic empty;
	logic pop = 1'b0;

	quotient_board board = new();
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	longint unsigned cycles = 0;

	signed_mul_div_round u_top (
		.clk(clk), .arst_n(arst_n), .item(item), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: sample at the rising edge, decide pop at the falling edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && pop && !empty) board.check_word(result);
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	function logic [63:0] pick_value();
		case ($urandom_range(7))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return $urandom_range(3) - 64'd1;
			3: return {$urandom, $urandom};
			4: return {{32{$urandom_range(1) == 1}}, $urandom};
			5: return {32'd0, $urandom};
			6: return {$urandom, $urandom} >> $urandom_range(63);
			default: return -({$urandom, $urandom} >> $urandom_range(63));
		endcase
	endfunction

	// Called at a falling edge; push stays high into the next word when there is no gap.
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		item <= w;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_word(w);
		@(negedge clk);
	endtask

	task automatic send_fields(logic cmd, logic [63:0] a, logic [63:0] b, logic [63:0] c);
		in_word_t w;
		w.command = cmd;
		w.factor_a = a;
		w.factor_b = b;
		w.divisor = c;
		send_word(w);
	endtask

	task automatic send_random(int unsigned n);
		logic [63:0] c;
		for (int unsigned i = 0; i < n; i++) begin
			// Mostly positive divisors so that the arithmetic path is exercised.
			c = pick_value();
			if ($urandom_range(9) != 0 && (c == 0 || c[63])) c = {1'b0, c[62:0]} | 64'd1;
			send_fields(1'($urandom_range(1)), pick_value(), pick_value(), c);
		end
	endtask

	localparam logic [63:0] MaxPos = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_fields(CMD_FLOOR, 64'd7, 64'd3, 64'd0);
		send_fields(CMD_CEIL, 64'd7, 64'd3, MinNeg);
		send_fields(CMD_FLOOR, 64'd0, MaxPos, 64'd5);
		send_fields(CMD_CEIL, MinNeg, 64'd0, 64'd5);
		send_fields(CMD_FLOOR, 64'd7, 64'd3, 64'd2);
		send_fields(CMD_CEIL, 64'd7, 64'd3, 64'd2);
		send_fields(CMD_FLOOR, -64'd7, 64'd3, 64'd2);
		send_fields(CMD_CEIL, -64'd7, 64'd3, 64'd2);
		send_fields(CMD_FLOOR, MaxPos, MaxPos, 64'd1);
		send_fields(CMD_FLOOR, MaxPos, MaxPos, MaxPos);
		send_fields(CMD_FLOOR, MinNeg, 64'd1, 64'd1);
		send_fields(CMD_FLOOR, MinNeg, -64'd1, 64'd1);
		send_fields(CMD_FLOOR, MinNeg, MinNeg, MaxPos);
		send_fields(CMD_CEIL, MaxPos, 64'd2, 64'd2);
		send_fields(CMD_CEIL, MaxPos, 64'd3, 64'd3);
		send_fields(CMD_FLOOR, MinNeg, 64'd3, 64'd2);
		send_fields(CMD_FLOOR, MinNeg, 64'd2, 64'd2);
		send_fields(CMD_CEIL, MaxPos, MaxPos, 64'h7fff_ffff_ffff_fffe);
		send_fields(CMD_FLOOR, -64'd1, MaxPos, MaxPos);
		send_fields(CMD_CEIL, 64'hffff_ffff, 64'h1_0000_0001, 64'd2);

		send_idle = 12;
		recv_idle = 73;
		send_random(580);
		push <= 1'b0;
		// Drain fully once so the pipeline empties with no input pending.
		while (board.pending.size() != 0) @(negedge clk);
		send_idle = 73;
		recv_idle = 12;
		send_random(560);
		send_idle = 0;
		recv_idle = 0;
		send_random(560);
		push <= 1'b0;

		while (board.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (board.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
